// ----- design/sfmm_pkg.sv -----
// shared types and constants for the subsampled frame statistics block
`default_nettype none

package sfmm_pkg;

  localparam int unsigned MaxWidth  = 4096;
  localparam int unsigned PixW      = 16;
  localparam int unsigned FwW       = 13;
  localparam int unsigned StepW     = 8;
  localparam int unsigned ShiftW    = 4;
  localparam int unsigned ColW      = $clog2(MaxWidth);
  localparam int unsigned SumW      = 40;
  localparam int unsigned CountW    = 25;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 13;
  localparam int unsigned QueueDepth = 2;

  // register indexes on the config port
  localparam logic [CfgIdxW-1:0] RegFrameWidth = 2'd0;
  localparam logic [CfgIdxW-1:0] RegSubStep    = 2'd1;
  localparam logic [CfgIdxW-1:0] RegValShift   = 2'd2;

  typedef struct packed {
    logic [FwW-1:0]    frame_width;
    logic [StepW-1:0]  subsample_step;
    logic [ShiftW-1:0] value_shift;
  } cfg_t;

  // per-frame totals handed from front to back
  typedef struct packed {
    logic [PixW-1:0]   min_value;
    logic [PixW-1:0]   max_value;
    logic [SumW-1:0]   sum;
    logic [CountW-1:0] count;
  } frame_rec_t;

endpackage

`default_nettype wire

// ----- design/sfmm_front.sv -----
// front end: raster tracking, subsampling and running min/max/sum/count
`default_nettype none

module sfmm_front import sfmm_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cfg_t             cfg_i,
  input  wire logic             pix_valid_i,
  output logic                  pix_ready_o,
  input  wire logic [PixW-1:0]  pixel_value_i,
  input  wire logic             frame_end_i,
  input  wire logic             q_full_i,
  output logic                  q_push_o,
  output frame_rec_t            q_data_o
);

  logic [ColW-1:0]   col_pos_q, col_pos_d;
  logic [StepW-1:0]  col_ph_q, col_ph_d;
  logic [StepW-1:0]  row_ph_q, row_ph_d;
  logic [PixW-1:0]   min_q, min_d;
  logic [PixW-1:0]   max_q, max_d;
  logic [SumW-1:0]   sum_q, sum_d;
  logic [CountW-1:0] cnt_q, cnt_d;

  logic [FwW-1:0]    width_eff;
  logic [StepW-1:0]  step_eff;
  logic [PixW-1:0]   pix_sh;
  logic              take;
  logic              fire;
  logic [PixW-1:0]   min_n, max_n;
  logic [SumW-1:0]   sum_n;
  logic [CountW-1:0] cnt_n;
  logic [FwW-1:0]    col_inc;
  logic [StepW:0]    col_ph_inc, row_ph_inc;

  // only the last pixel of a frame needs room in the queue
  assign pix_ready_o = !(frame_end_i && q_full_i);
  assign fire        = pix_valid_i && pix_ready_o;

  always_comb begin
    if (cfg_i.frame_width == '0) begin
      width_eff = FwW'(1);
    end else if (cfg_i.frame_width > FwW'(MaxWidth)) begin
      width_eff = FwW'(MaxWidth);
    end else begin
      width_eff = cfg_i.frame_width;
    end
    step_eff = (cfg_i.subsample_step == '0) ? StepW'(1) : cfg_i.subsample_step;
  end

  assign pix_sh = pixel_value_i >> cfg_i.value_shift;
  // sample while both phases are zero and the count has not saturated
  assign take   = (col_ph_q == '0) && (row_ph_q == '0) && !cnt_q[CountW-1];

  always_comb begin
    min_n = min_q;
    max_n = max_q;
    sum_n = sum_q;
    cnt_n = cnt_q;
    if (take) begin
      if (pix_sh < min_q) min_n = pix_sh;
      if (pix_sh > max_q) max_n = pix_sh;
      sum_n = sum_q + SumW'(pix_sh);
      cnt_n = cnt_q + CountW'(1);
    end
  end

  assign col_inc    = FwW'(col_pos_q) + FwW'(1);
  assign col_ph_inc = {1'b0, col_ph_q} + (StepW+1)'(1);
  assign row_ph_inc = {1'b0, row_ph_q} + (StepW+1)'(1);

  always_comb begin
    col_pos_d = col_pos_q;
    col_ph_d  = col_ph_q;
    row_ph_d  = row_ph_q;
    min_d     = min_q;
    max_d     = max_q;
    sum_d     = sum_q;
    cnt_d     = cnt_q;
    if (fire) begin
      if (col_inc >= width_eff) begin
        col_pos_d = '0;
        col_ph_d  = '0;
        row_ph_d  = (row_ph_inc >= {1'b0, step_eff}) ? '0 : row_ph_inc[StepW-1:0];
      end else begin
        col_pos_d = col_inc[ColW-1:0];
        col_ph_d  = (col_ph_inc >= {1'b0, step_eff}) ? '0 : col_ph_inc[StepW-1:0];
      end
      min_d = min_n;
      max_d = max_n;
      sum_d = sum_n;
      cnt_d = cnt_n;
      if (frame_end_i) begin
        col_pos_d = '0;
        col_ph_d  = '0;
        row_ph_d  = '0;
        min_d     = '1;
        max_d     = '0;
        sum_d     = '0;
        cnt_d     = '0;
      end
    end
  end

  assign q_push_o           = fire && frame_end_i;
  assign q_data_o.min_value = min_n;
  assign q_data_o.max_value = max_n;
  assign q_data_o.sum       = sum_n;
  assign q_data_o.count     = cnt_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_pos_q <= '0;
      col_ph_q  <= '0;
      row_ph_q  <= '0;
      min_q     <= '1;
      max_q     <= '0;
      sum_q     <= '0;
      cnt_q     <= '0;
    end else begin
      col_pos_q <= col_pos_d;
      col_ph_q  <= col_ph_d;
      row_ph_q  <= row_ph_d;
      min_q     <= min_d;
      max_q     <= max_d;
      sum_q     <= sum_d;
      cnt_q     <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/sfmm_fifo.sv -----
// two-entry queue of frame totals between front and back
`default_nettype none

module sfmm_fifo import sfmm_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire frame_rec_t push_data_i,
  output logic            full_o,
  input  wire logic       pop_i,
  output logic            valid_o,
  output frame_rec_t      pop_data_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  frame_rec_t                mem_q [QueueDepth];
  logic [PtrW-1:0]           wr_ptr_q, rd_ptr_q;
  logic [$clog2(QueueDepth+1)-1:0] fill_q, fill_d;

  assign full_o     = (fill_q == ($clog2(QueueDepth+1))'(QueueDepth));
  assign valid_o    = (fill_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    fill_d = fill_q;
    if (push_i && !pop_i) fill_d = fill_q + 1'b1;
    if (pop_i && !push_i) fill_d = fill_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      fill_q <= fill_d;
      if (push_i) wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth-1)) ? '0 : wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth-1)) ? '0 : rd_ptr_q + 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- design/sfmm_back.sv -----
// back end: bit-serial mean divide and result register
`default_nettype none

module sfmm_back import sfmm_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               rec_valid_i,
  input  wire frame_rec_t         rec_i,
  output logic                    rec_pop_o,
  output logic                    res_valid_o,
  input  wire logic               res_ready_i,
  output logic [PixW-1:0]         min_value_o,
  output logic [PixW-1:0]         max_value_o,
  output logic [PixW-1:0]         mean_value_o,
  output logic [CountW-1:0]       sample_total_o
);

  typedef enum logic [1:0] {StIdle, StDiv, StOut} state_e;

  localparam int unsigned StepCntW = $clog2(PixW);

  state_e              state_q;
  logic [SumW-1:0]     rem_q;
  logic [SumW-1:0]     div_q;
  logic [PixW-1:0]     quo_q;
  logic [StepCntW-1:0] step_q;
  logic                empty_q;
  logic                fits;
  logic [SumW-1:0]     diff;
  logic [PixW-1:0]     quo_n;

  // mean fits 16 bits since sum <= count * 65535, so 16 quotient bits suffice
  assign diff      = rem_q - div_q;
  assign fits      = (rem_q >= div_q);
  assign quo_n     = {quo_q[PixW-2:0], fits};
  assign rec_pop_o = (state_q == StIdle) && rec_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      res_valid_o    <= 1'b0;
      min_value_o    <= '0;
      max_value_o    <= '0;
      mean_value_o   <= '0;
      sample_total_o <= '0;
      empty_q        <= 1'b0;
      rem_q          <= '0;
      div_q          <= '0;
      quo_q          <= '0;
      step_q         <= '0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (rec_valid_i) begin
            min_value_o    <= rec_i.min_value;
            max_value_o    <= rec_i.max_value;
            sample_total_o <= rec_i.count;
            empty_q        <= (rec_i.count == '0);
            rem_q          <= rec_i.sum;
            div_q          <= {rec_i.count, (SumW-CountW)'(0)};
            quo_q          <= '0;
            step_q         <= StepCntW'(PixW-1);
            state_q        <= StDiv;
          end
        end
        StDiv: begin
          if (fits) rem_q <= diff;
          div_q  <= div_q >> 1;
          quo_q  <= quo_n;
          step_q <= step_q - 1'b1;
          if (step_q == '0) begin
            mean_value_o <= empty_q ? '0 : quo_n;
            res_valid_o  <= 1'b1;
            state_q      <= StOut;
          end
        end
        StOut: begin
          if (res_ready_i) begin
            res_valid_o <= 1'b0;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/subsampled_frame_min_max_mean.sv -----
// top level: subsampled frame min/max/mean/count statistics
//
// pixels arrive on the pix channel (valid/ready), one 16-bit word per
// transfer in raster order, frame_end_i set on the last pixel of a frame.
// each pixel is shifted right by value_shift; pixels whose column and row
// are multiples of subsample_step feed a running min, max, sum and count.
// the front end takes one pixel per cycle; it only stalls the last pixel
// of a frame, when the two-entry queue of frame totals is full.
// the back end divides sum by count bit-serially, one quotient bit per
// cycle, and takes the next frame total from the queue only once the
// previous result has been accepted on res_ready_i.
// one result transfer per frame on the res channel; while the receiver
// stalls, the result is held and up to two more frames queue behind it.
// config is a plain write port (frame_width, subsample_step, value_shift)
// and must only be written while the block is idle.
// reset (rst_ni low, async) clears the raster position, the running totals,
// the queue and the output, and loads width 640, step 1, shift 0.
`default_nettype none

module subsampled_frame_min_max_mean import sfmm_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // config write port
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  // pixel input
  input  wire logic                pix_valid_i,
  output logic                     pix_ready_o,
  input  wire logic [PixW-1:0]     pixel_value_i,
  input  wire logic                frame_end_i,
  // frame result
  output logic                     res_valid_o,
  input  wire logic                res_ready_i,
  output logic [PixW-1:0]          min_value_o,
  output logic [PixW-1:0]          max_value_o,
  output logic [PixW-1:0]          mean_value_o,
  output logic [CountW-1:0]        sample_total_o
);

  cfg_t       cfg_q;
  logic       q_push, q_full, q_pop, q_valid;
  frame_rec_t q_wdata, q_rdata;

  // config registers, taken straight from the write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width    <= FwW'(640);
      cfg_q.subsample_step <= StepW'(1);
      cfg_q.value_shift    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegFrameWidth: cfg_q.frame_width    <= cfg_data_i[FwW-1:0];
        RegSubStep:    cfg_q.subsample_step <= cfg_data_i[StepW-1:0];
        RegValShift:   cfg_q.value_shift    <= cfg_data_i[ShiftW-1:0];
        default:       ;  // unused index, write dropped
      endcase
    end
  end

  // front end: one pixel per cycle, stalled by a full queue at frame end
  sfmm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .pix_valid_i   (pix_valid_i),
    .pix_ready_o   (pix_ready_o),
    .pixel_value_i (pixel_value_i),
    .frame_end_i   (frame_end_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_data_o      (q_wdata)
  );

  // frame totals waiting for the divider
  sfmm_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_rdata)
  );

  // back end: mean divide and result register
  sfmm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rec_valid_i    (q_valid),
    .rec_i          (q_rdata),
    .rec_pop_o      (q_pop),
    .res_valid_o    (res_valid_o),
    .res_ready_i    (res_ready_i),
    .min_value_o    (min_value_o),
    .max_value_o    (max_value_o),
    .mean_value_o   (mean_value_o),
    .sample_total_o (sample_total_o)
  );

endmodule

`default_nettype wire
